// ===== rtl/arm32_bank_pkg.sv =====
`default_nettype none
package arm32_bank_pkg;

  typedef enum logic [2:0] {
    K_READ        = 3'd0,
    K_WRITE       = 3'd1,
    K_MODE_READ   = 3'd2,
    K_MODE_WRITE  = 3'd3,
    K_CPSR_READ   = 3'd4,
    K_CPSR_UPDATE = 3'd5,
    K_SPSR_READ   = 3'd6,
    K_SPSR_UPDATE = 3'd7
  } kind_t;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_MON = 5'h16;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [1:0] CFG_USER_MASK = 2'd0;
  localparam logic [1:0] CFG_PRIV_MASK = 2'd1;
  localparam logic [1:0] CFG_BANKING   = 2'd2;

  localparam logic [3:0] REG_HIGH_FIRST = 4'd8;
  localparam logic [3:0] REG_SP         = 4'd13;
  localparam logic [3:0] REG_LR         = 4'd14;
  localparam logic [3:0] REG_PC         = 4'd15;

  // memory addresses: 0..12 gpr, 13 sp, 14 lr, 15 pc, 16..20 usr high,
  // 21..25 fiq high, 26..32 bank sp, 33..39 bank lr, 40..45 spsr
  localparam int unsigned MEM_DEPTH = 46;
  localparam int unsigned AW        = 6;
  localparam logic [AW-1:0] A_HUSR  = 6'd16;
  localparam logic [AW-1:0] A_HFIQ  = 6'd21;
  localparam logic [AW-1:0] A_BSP   = 6'd26;
  localparam logic [AW-1:0] A_BLR   = 6'd33;
  localparam logic [AW-1:0] A_SPSR  = 6'd40;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
  } slot_t;

  function automatic slot_t mode_slot(input logic [4:0] m);
    slot_t s;
    s.valid = 1'b1;
    case (m)
      MODE_USR, MODE_SYS: s.slot = 3'd0;
      MODE_FIQ: s.slot = 3'd1;
      MODE_IRQ: s.slot = 3'd2;
      MODE_SVC: s.slot = 3'd3;
      MODE_MON: s.slot = 3'd4;
      MODE_ABT: s.slot = 3'd5;
      MODE_UND: s.slot = 3'd6;
      default: begin
        s.valid = 1'b0;
        s.slot  = 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/arm32_banked_register_file_core.sv =====
// ARMv7 banked register file.
// in_ channel: one beat per operation; out_ channel: one result beat each.
// cfg_ channel writes user_bits_mask (0), priv_bits_mask (1), banking (2);
// cfg_ready is high only while the block is idle.
// All registers and banks but the CPSRs live in one 46-entry single-port-read
// RAM, so operations on them are sequences of read, modify, write-back steps.
// Steps from the accepted beat to out_tvalid: register and SPSR operations
// pass RD1, RD2, WB and DONE; a CPSR read and a CPSR update without bank
// traffic pass RD1 and DONE; a mode change saves and restores 7 registers
// (one RAM read and one write each), or does only the save or only the
// restore, before DONE. One operation is in flight at a time; a new beat is
// taken only while the block is in idle.
// The result sits in an output register. While the receiver stalls the next
// operation still runs and waits at its last step until that register has
// emptied; no further beat is taken meanwhile.
// Reset (rst_n low, synchronous) starts a clearing pass that writes zero to
// each of the 46 RAM entries in turn; no beat is taken during it. CPSRs and config reset at once.
`default_nettype none
module arm32_banked_register_file_core
  import arm32_bank_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] kind, [7:3] target_mode, [11:8] reg_index, [43:12] value,
  // [75:44] mask, zero pad to 80
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] read_data, [32] status, zero pad to 40
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_WB, S_SAVE_RD, S_SAVE_WR,
    S_REST_RD, S_REST_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [31:0] user_mask_r, priv_mask_r, live_cpsr_r, priv_cpsr_r;
  logic        bank_en_r;
  kind_t       kind_r;
  logic [4:0]  tmode_r;
  logic [3:0]  reg_r;
  logic [31:0] val_r, msk_r, rd_r;
  logic        st_r, out_valid_r;
  logic [31:0] out_rd_r;
  logic        out_st_r;
  logic [AW-1:0] cnt_r;
  logic [2:0]  step_r;
  logic [4:0]  old_mode_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  arm32_bank_ram #(.DEPTH(MEM_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [4:0] cur_mode;
  slot_t      cur_s, tgt_s, old_s;
  assign cur_mode = priv_cpsr_r[4:0];
  assign cur_s    = mode_slot(cur_mode);
  assign tgt_s    = mode_slot(tmode_r);
  assign old_s    = mode_slot(old_mode_r);

  // address of register step k (0..4 high, 5 sp, 6 lr) in a mode's bank
  function automatic logic [AW-1:0] bank_addr(input logic [2:0] k,
                                               input logic [4:0] m,
                                               input slot_t s);
    logic [AW-1:0] a;
    if (k < 3'd5) begin
      a = ((m == MODE_FIQ) ? A_HFIQ : A_HUSR) + AW'(k);
    end else if (k == 3'd5) begin
      a = A_BSP + AW'(s.slot);
    end else begin
      a = A_BLR + AW'(s.slot);
    end
    return a;
  endfunction

  function automatic logic [AW-1:0] live_addr(input logic [2:0] k);
    return (k < 3'd5) ? AW'(REG_HIGH_FIRST) + AW'(k) : AW'(k) + AW'(8);
  endfunction

  // per-operation access plan
  logic          is_write;
  logic          p_rd_ok;
  logic [AW-1:0] p_a1, p_a2;
  logic          p_w1, p_w2;
  logic          other_live;

  always_comb begin
    is_write   = 1'b0;
    p_rd_ok    = 1'b1;
    p_a1       = AW'(reg_r);
    p_a2       = AW'(reg_r);
    p_w1       = 1'b0;
    p_w2       = 1'b0;
    other_live = (kind_r == K_READ) || (kind_r == K_WRITE) || (tmode_r == cur_mode);
    if (kind_r == K_WRITE || kind_r == K_MODE_WRITE) is_write = 1'b1;
    if (kind_r == K_SPSR_READ || kind_r == K_SPSR_UPDATE) begin
      p_a1    = A_SPSR + AW'(cur_s.slot) - AW'(1);
      p_rd_ok = cur_s.valid && (cur_s.slot != 3'd0);
      p_w1    = (kind_r == K_SPSR_UPDATE) && p_rd_ok && (cur_mode != MODE_USR);
    end else if (other_live) begin
      p_w1 = is_write;
      if (reg_r >= REG_HIGH_FIRST && reg_r < REG_SP) begin
        p_a2 = ((cur_mode == MODE_FIQ) ? A_HFIQ : A_HUSR) + AW'(reg_r - REG_HIGH_FIRST);
        p_w2 = is_write;
      end else if (reg_r == REG_SP || reg_r == REG_LR) begin
        p_a2 = ((reg_r == REG_SP) ? A_BSP : A_BLR) + AW'(cur_s.slot);
        p_w2 = is_write && cur_s.valid;
      end
    end else begin
      if (reg_r >= REG_HIGH_FIRST && reg_r < REG_SP) begin
        if (cur_mode == MODE_FIQ) p_a1 = A_HUSR + AW'(reg_r - REG_HIGH_FIRST);
        else if (tmode_r == MODE_FIQ) p_a1 = A_HFIQ + AW'(reg_r - REG_HIGH_FIRST);
      end else if (reg_r == REG_SP || reg_r == REG_LR) begin
        p_a1    = ((reg_r == REG_SP) ? A_BSP : A_BLR) + AW'(tgt_s.slot);
        p_rd_ok = tgt_s.valid;
      end
      p_w1 = is_write && p_rd_ok;
    end
  end

  logic [31:0] cv, new_priv, new_live;
  logic        mode_swap;
  slot_t       new_s;
  assign cv        = val_r & msk_r;
  assign mode_swap = (msk_r[4:0] != 5'd0) && (cur_mode != cv[4:0]);
  assign new_priv  = (priv_cpsr_r & ~(priv_mask_r & msk_r)) | (cv & priv_mask_r);
  assign new_live  = (live_cpsr_r & ~(user_mask_r & msk_r)) | (cv & user_mask_r);
  assign new_s     = mode_slot(new_priv[4:0]);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = 32'd0;
    raddr = p_a1;
    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r;
      end
      S_RD2: begin
        we    = p_w1;
        waddr = p_a1;
        wdata = (kind_r == K_SPSR_UPDATE) ? ((rdata & ~msk_r) | (val_r & msk_r)) : val_r;
      end
      S_WB: begin
        we    = p_w2;
        waddr = p_a2;
        wdata = val_r;
      end
      S_SAVE_RD: raddr = live_addr(step_r);
      S_SAVE_WR: begin
        we    = 1'b1;
        waddr = bank_addr(step_r, old_mode_r, old_s);
        wdata = rdata;
      end
      S_REST_RD: raddr = bank_addr(step_r, cur_mode, cur_s);
      S_REST_WR: begin
        we    = 1'b1;
        waddr = live_addr(step_r);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_st_r, out_rd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      user_mask_r <= 32'hF800_0000;
      priv_mask_r <= 32'h07FF_FFFF;
      bank_en_r   <= 1'b1;
      live_cpsr_r <= 32'h110;
      priv_cpsr_r <= 32'h1D3;
      step_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USER_MASK: user_mask_r <= cfg_data;
          CFG_PRIV_MASK: priv_mask_r <= cfg_data;
          CFG_BANKING:   bank_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(MEM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            kind_r  <= kind_t'(in_tdata[2:0]);
            tmode_r <= in_tdata[7:3];
            reg_r   <= in_tdata[11:8];
            val_r   <= in_tdata[43:12];
            msk_r   <= in_tdata[75:44];
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          step_r <= '0;
          case (kind_r)
            K_CPSR_READ: begin
              rd_r    <= bank_en_r ? ((live_cpsr_r & user_mask_r) |
                                      (priv_cpsr_r & ~user_mask_r)) : live_cpsr_r;
              st_r    <= 1'b0;
              state_r <= S_DONE;
            end
            K_CPSR_UPDATE: begin
              rd_r        <= 32'd0;
              st_r        <= 1'b0;
              old_mode_r  <= cur_mode;
              if (mode_swap && bank_en_r && cur_s.valid) begin
                state_r <= S_SAVE_RD;
              end else begin
                priv_cpsr_r <= new_priv;
                live_cpsr_r <= new_live;
                state_r <= (mode_swap && bank_en_r && new_s.valid) ? S_REST_RD : S_DONE;
              end
            end
            default: state_r <= S_RD2;
          endcase
        end
        S_RD2: begin
          rd_r    <= (is_write || kind_r == K_SPSR_UPDATE || !p_rd_ok) ? 32'd0 : rdata;
          st_r    <= (kind_r == K_SPSR_UPDATE) && (cur_mode == MODE_USR);
          state_r <= S_WB;
        end
        S_WB: state_r <= S_DONE;
        S_SAVE_RD: state_r <= S_SAVE_WR;
        S_SAVE_WR: begin
          if (step_r == 3'd6) begin
            step_r      <= '0;
            priv_cpsr_r <= new_priv;
            live_cpsr_r <= new_live;
            state_r     <= new_s.valid ? S_REST_RD : S_DONE;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= S_SAVE_RD;
          end
        end
        S_REST_RD: state_r <= S_REST_WR;
        S_REST_WR: begin
          if (step_r == 3'd6) begin
            state_r <= S_DONE;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= S_REST_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= rd_r;
            out_st_r    <= st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("beat taken while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_tready)) |=> out_tvalid)
    else $error("result lost");
  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_tvalid) else $error("result during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/arm32_bank_ram.sv =====
`default_nettype none
module arm32_bank_ram #(
  parameter int unsigned DEPTH = 46,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== verif/arm32_bank_checker.sv =====
`default_nettype none
module arm32_bank_checker
  import arm32_bank_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count
);

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } result_t;

  logic [31:0] user_mask, priv_mask;
  logic        banking;
  logic [31:0] gpr [13];
  logic [31:0] sp_q, lr_q, pc_q, live_cpsr, priv_cpsr;
  logic [31:0] high_usr [5], high_fiq [5];
  logic [31:0] sp_bank [7], lr_bank [7], spsr_bank [6];
  result_t     results_due [$];

  function automatic int slot_of(input logic [4:0] m);
    case (m)
      MODE_USR, MODE_SYS: return 0;
      MODE_FIQ: return 1;
      MODE_IRQ: return 2;
      MODE_SVC: return 3;
      MODE_MON: return 4;
      MODE_ABT: return 5;
      MODE_UND: return 6;
      default: return -1;
    endcase
  endfunction

  function automatic logic [4:0] mode_now();
    return priv_cpsr[4:0];
  endfunction

  task automatic swap_bank(input bit save);
    logic [4:0] m;
    int s;
    m = mode_now();
    s = slot_of(m);
    if (!banking || s < 0) return;
    for (int i = 0; i < 5; i++) begin
      if (save) begin
        if (m == MODE_FIQ) high_fiq[i] = gpr[8+i];
        else high_usr[i] = gpr[8+i];
      end else begin
        gpr[8+i] = (m == MODE_FIQ) ? high_fiq[i] : high_usr[i];
      end
    end
    if (save) begin
      sp_bank[s] = sp_q;
      lr_bank[s] = lr_q;
    end else begin
      sp_q = sp_bank[s];
      lr_q = lr_bank[s];
    end
  endtask

  function automatic logic [31:0] live_rd(input logic [3:0] r);
    if (r < REG_SP) return gpr[r];
    if (r == REG_SP) return sp_q;
    if (r == REG_LR) return lr_q;
    return pc_q;
  endfunction

  task automatic live_wr(input logic [3:0] r, input logic [31:0] v);
    logic [4:0] m;
    int s;
    m = mode_now();
    s = slot_of(m);
    if (r < REG_HIGH_FIRST) gpr[r] = v;
    else if (r < REG_SP) begin
      gpr[r] = v;
      if (m == MODE_FIQ) high_fiq[r-8] = v;
      else high_usr[r-8] = v;
    end else if (r == REG_SP) begin
      sp_q = v;
      if (s >= 0) sp_bank[s] = v;
    end else if (r == REG_LR) begin
      lr_q = v;
      if (s >= 0) lr_bank[s] = v;
    end else pc_q = v;
  endtask

  task automatic apply_op(input logic [79:0] d, output result_t res);
    kind_t       k;
    logic [4:0]  t, m;
    logic [3:0]  r;
    logic [31:0] v, msk;
    int          s, ts;
    bit          change;
    k = kind_t'(d[2:0]);
    t = d[7:3];
    r = d[11:8];
    v = d[43:12];
    msk = d[75:44];
    m = mode_now();
    s = slot_of(m);
    ts = slot_of(t);
    res = '0;
    case (k)
      K_READ: res.read_data = live_rd(r);
      K_WRITE: live_wr(r, v);
      K_MODE_READ: begin
        if (t == m) res.read_data = live_rd(r);
        else if (r < REG_HIGH_FIRST || r == REG_PC) res.read_data = live_rd(r);
        else if (r < REG_SP) begin
          if (m == MODE_FIQ) res.read_data = high_usr[r-8];
          else if (t == MODE_FIQ) res.read_data = high_fiq[r-8];
          else res.read_data = gpr[r];
        end else if (ts >= 0) res.read_data = (r == REG_SP) ? sp_bank[ts] : lr_bank[ts];
      end
      K_MODE_WRITE: begin
        if (t == m) live_wr(r, v);
        else if (r < REG_HIGH_FIRST) gpr[r] = v;
        else if (r < REG_SP) begin
          if (m == MODE_FIQ) high_usr[r-8] = v;
          else if (t == MODE_FIQ) high_fiq[r-8] = v;
          else gpr[r] = v;
        end else if (r == REG_SP) begin
          if (ts >= 0) sp_bank[ts] = v;
        end else if (r == REG_LR) begin
          if (ts >= 0) lr_bank[ts] = v;
        end else pc_q = v;
      end
      K_CPSR_READ:
        res.read_data = banking ? ((live_cpsr & user_mask) | (priv_cpsr & ~user_mask))
                                : live_cpsr;
      K_CPSR_UPDATE: begin
        v = v & msk;
        change = (msk[4:0] != 0) && (m != v[4:0]);
        if (change) swap_bank(1);
        priv_cpsr = (priv_cpsr & ~(priv_mask & msk)) | (v & priv_mask);
        live_cpsr = (live_cpsr & ~(user_mask & msk)) | (v & user_mask);
        if (change) swap_bank(0);
      end
      K_SPSR_READ: if (s >= 1) res.read_data = spsr_bank[s-1];
      default: begin
        if (m == MODE_USR) res.status = 1'b1;
        else if (s >= 1) spsr_bank[s-1] = (spsr_bank[s-1] & ~msk) | (v & msk);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t exp_r, got;
    if (!rst_n) begin
      user_mask = 32'hF800_0000;
      priv_mask = 32'h07FF_FFFF;
      banking = 1'b1;
      for (int i = 0; i < 13; i++) gpr[i] = '0;
      sp_q = '0; lr_q = '0; pc_q = '0;
      live_cpsr = 32'h110;
      priv_cpsr = 32'h1D3;
      for (int i = 0; i < 5; i++) begin
        high_usr[i] = '0;
        high_fiq[i] = '0;
      end
      for (int i = 0; i < 7; i++) begin
        sp_bank[i] = '0;
        lr_bank[i] = '0;
      end
      for (int i = 0; i < 6; i++) spsr_bank[i] = '0;
      results_due.delete();
      fail_count <= 0;
      pending <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USER_MASK: user_mask = cfg_data;
          CFG_PRIV_MASK: priv_mask = cfg_data;
          CFG_BANKING: banking = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        apply_op(in_tdata, exp_r);
        results_due.push_back(exp_r);
      end
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[31:0];
        got.status = out_tdata[32];
        result_count <= result_count + 1;
        if (results_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (exp_r != got) begin
            if (fail_count < 10)
              $display("mismatch: exp data %h status %b, got data %h status %b",
                       exp_r.read_data, exp_r.status, got.read_data, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= results_due.size();
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_arm32_banked_register_file_core.sv =====
`default_nettype none
module tb_arm32_banked_register_file_core;
  import arm32_bank_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending, result_count;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int          cycles = 0;
  int          ops_sent = 0;

  localparam int CYCLE_LIMIT = 1_000_000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  arm32_banked_register_file_core u_top (.*);

  arm32_bank_checker u_chk (.*);

  localparam logic [4:0] MODES [8] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                       MODE_MON, MODE_ABT, MODE_UND, MODE_SYS};

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver side
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_op(input kind_t k, input logic [4:0] t, input logic [3:0] r,
                         input logic [31:0] v, input logic [31:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {4'b0, m, v, r, t, k};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    ops_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] pick_mode();
    if ($urandom_range(9) == 0) return 5'($urandom);
    return MODES[$urandom_range(7)];
  endfunction

  task automatic random_op();
    kind_t       k;
    logic [31:0] m;
    k = kind_t'($urandom_range(7));
    m = $urandom;
    if (k == K_CPSR_UPDATE && $urandom_range(2) != 0) m = {m[31:5], 5'h1F};
    send_op(k, pick_mode(), 4'($urandom), $urandom, m);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    // directed
    send_op(K_READ, 5'h00, 4'd0, '0, '0);
    send_op(K_SPSR_UPDATE, 5'h00, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(K_CPSR_READ, 5'h00, 4'd0, '0, '0);
    for (int i = 0; i < 16; i += 3)
      send_op(K_WRITE, 5'h00, 4'(i), 32'hFFFF_FFFF - i, '0);
    send_op(K_WRITE, 5'h00, REG_PC, 32'hFFFF_FFFF, '0);
    send_op(K_CPSR_UPDATE, 5'h00, 4'd0, {27'h7FF_FFFF, MODE_FIQ}, 32'hFFFF_FFFF);
    send_op(K_MODE_WRITE, MODE_IRQ, REG_SP, 32'hA5A5_5A5A, '0);
    send_op(K_MODE_READ, MODE_USR, 4'd9, '0, '0);
    send_op(K_MODE_WRITE, 5'h05, REG_LR, 32'h1234, '0);
    send_op(K_MODE_READ, 5'h05, REG_LR, '0, '0);
    send_op(K_SPSR_UPDATE, 5'h00, 4'd0, 32'hDEAD_BEEF, 32'h0FF0_FFFF);
    send_op(K_SPSR_READ, 5'h00, 4'd0, '0, '0);
    send_op(K_CPSR_UPDATE, 5'h00, 4'd0, 32'h3, 32'h1F);
    send_op(K_WRITE, 5'h00, 4'd10, 32'h0BAD_F00D, '0);
    send_op(K_CPSR_UPDATE, 5'h00, 4'd0, {27'h0, MODE_SYS}, 32'h1F);
    send_op(K_SPSR_UPDATE, 5'h00, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(K_MODE_READ, MODE_FIQ, 4'd10, '0, '0);
    send_op(K_CPSR_READ, 5'h00, 4'd0, '0, '0);
    drain();
    // phases: idling mix and configuration
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // config only with nothing in flight
      if (ph inside {1, 2, 3, 5, 6}) drain();
      case (ph)
        1: write_cfg(CFG_BANKING, 32'h0);
        2: begin
          write_cfg(CFG_BANKING, 32'h1);
          write_cfg(CFG_USER_MASK, 32'hFFFF_FFFF);
          write_cfg(CFG_PRIV_MASK, 32'h0);
        end
        3: begin
          write_cfg(CFG_USER_MASK, 32'h0);
          write_cfg(CFG_PRIV_MASK, 32'hFFFF_FFFF);
        end
        5: begin
          write_cfg(CFG_USER_MASK, $urandom);
          write_cfg(CFG_PRIV_MASK, $urandom | 32'h1F);
        end
        6: begin
          write_cfg(CFG_USER_MASK, 32'hF800_0000);
          write_cfg(CFG_PRIV_MASK, 32'h07FF_FFFF);
        end
        default: ;
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          repeat (6) random_op();
        join
      end
      repeat (140) random_op();
      if (ph == 2) drain();
    end
    drain();
    $display("ran %0d operations with %0d results over %0d cycles", ops_sent,
             result_count, cycles);
    $display("covered all kinds, all modes and bad modes, banking on and off, mask extremes");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
